// ----- rtl/prime_trial_division_generator_assert.svh -----
// ---------------------------------------------------------------------------
// Prime trial division generator assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PRIME_TRIAL_DIVISION_GENERATOR_ASSERT_SVH
`define PRIME_TRIAL_DIVISION_GENERATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTDG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ptdg: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PTDG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ptdg: next-cycle check failed");

`endif

// ----- rtl/ptdg_pkg.sv -----
// ---------------------------------------------------------------------------
// Prime trial division generator package
// Types and fixed constants shared by the generator and its remainder unit.
// ---------------------------------------------------------------------------
package ptdg_pkg;

  // Width of the run length register and of the ordinal field.
  localparam int unsigned COUNT_W = 14;
  // Width of one stored prime.
  localparam int unsigned ENTRY_W = 14;
  // Width of the square of a stored prime.
  localparam int unsigned SQ_W    = 2 * ENTRY_W;
  // Width of the status field.
  localparam int unsigned STS_W   = 2;

  typedef enum logic [STS_W-1:0] {
    ST_PRIME = 2'd0,
    ST_DONE  = 2'd1,
    ST_ABORT = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_RD,
    S_MUL,
    S_CMP,
    S_DIV,
    S_FOUND,
    S_COUNT,
    S_EMIT
  } state_e;

  // Status returned by the remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_sts_t;

endpackage

// ----- rtl/ptdg_rem_unit.sv -----
// ---------------------------------------------------------------------------
// Prime trial division remainder unit
// Bit-serial restoring division that reports whether the remainder is zero.
// ---------------------------------------------------------------------------
module ptdg_rem_unit #(
  parameter int unsigned DW = 18
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DW-1:0]             dividend_i,
  input  logic [ptdg_pkg::ENTRY_W-1:0] divisor_i,
  output ptdg_pkg::rem_sts_t        sts_o
);
  import ptdg_pkg::*;

  localparam int unsigned CNTW = $clog2(DW + 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNTW-1:0]     cnt_q, cnt_d;
  logic [DW-1:0]       dvd_q, dvd_d;
  logic [ENTRY_W-1:0]  div_q, div_d;
  logic [ENTRY_W-1:0]  rem_q, rem_d;
  logic [ENTRY_W:0]    rem_sh;

  // One quotient bit per cycle; the partial remainder always stays below the divisor.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    rem_sh = {rem_q, dvd_q[DW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNTW'(DW);
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, div_q}) begin
        rem_d = ENTRY_W'(rem_sh - {1'b0, div_q});
      end else begin
        rem_d = rem_sh[ENTRY_W-1:0];
      end
      dvd_d = {dvd_q[DW-2:0], 1'b0};
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign sts_o.zero = (rem_q == '0);

endmodule

// ----- rtl/prime_trial_division_generator.sv -----
// ---------------------------------------------------------------------------
// Prime trial division generator
// Returns the primes of a run one per request, found by trial division.
// ---------------------------------------------------------------------------
// Each word taken on the slave side asks for the next prime of the current
// run, and exactly one word comes back on the master side. A request that
// returns 2 goes through S_DECIDE, S_COUNT and S_EMIT into the output
// register, with one more pass through S_DECIDE when it carries a restart.
// Every later request walks odd candidates and divides each by the stored
// primes whose square does not exceed it. Each trial steps through table
// read, square, compare and the bit-serial remainder unit, which retires
// one dividend bit per cycle, and then sees the unit finish. The remainder
// unit is the pacing element. A request that reports an aborted run, or a
// run already over, goes from S_DECIDE straight to S_EMIT. One request is
// in flight at a time; the slave side is ready again once the result has
// been placed in the output register, and that register may still be
// waiting on the master side while the next request is taken. The prime
// table is a single-port synchronous memory of TABLE_DEPTH entries; it
// needs no clearing after reset, because only entries below the fill
// count are ever read. A write to target_count reaches goal as soon as it
// is registered, so it also acts on a request in flight; a value of zero
// acts as one.
// ---------------------------------------------------------------------------
module prime_trial_division_generator #(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned VALUE_BITS  = 18
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration: target_count.
  input  logic                          cfg_we_i,
  input  logic [ptdg_pkg::COUNT_W-1:0]  cfg_wdata_i,
  // Request stream.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // Bits from 0: restart, abort, six zero bits.
  input  logic [7:0]                    s_axis_tdata_i,
  // Result stream.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // Bits from 0: prime_value (VALUE_BITS), ordinal (14), zero fill to bytes.
  output logic [((VALUE_BITS + ptdg_pkg::COUNT_W + 7) / 8) * 8 - 1:0] m_axis_tdata_o,
  // last
  output logic                          m_axis_tlast_o,
  // Bits from 0: status (2).
  output logic [ptdg_pkg::STS_W-1:0]    m_axis_tuser_o
);
  import ptdg_pkg::*;

  localparam int unsigned ODW  = ((VALUE_BITS + COUNT_W + 7) / 8) * 8;
  localparam int unsigned IW   = $clog2(TABLE_DEPTH);
  localparam int unsigned FW   = IW + 1;
  localparam int unsigned NW   = VALUE_BITS + 1;
  localparam int unsigned CMPW = (NW > SQ_W) ? NW : SQ_W;
  localparam logic [NW-1:0] VMASK = {1'b0, {VALUE_BITS{1'b1}}};

  state_e                 state_q, state_d;
  logic [COUNT_W-1:0]     target_q;
  logic [VALUE_BITS-1:0]  cand_q, cand_d;
  logic [FW-1:0]          fill_q, fill_d;
  logic [COUNT_W-1:0]     found_q, found_d;
  logic                   run_over_q, run_over_d;
  logic                   restart_q, restart_d;
  logic                   abort_q, abort_d;
  logic [NW-1:0]          n_q, n_d;
  logic [FW-1:0]          idx_q, idx_d;
  logic [ENTRY_W-1:0]     f_q, f_d;
  logic [SQ_W-1:0]        sq_q, sq_d;
  status_e                res_sts_q, res_sts_d;
  logic                   res_last_q, res_last_d;

  logic                   out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0]  out_val_q, out_val_d;
  logic [COUNT_W-1:0]     out_ord_q, out_ord_d;
  logic                   out_last_q, out_last_d;
  status_e                out_sts_q, out_sts_d;

  logic [ENTRY_W-1:0]     mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]     rd_q;
  logic                   rd_en;
  logic                   wr_en;
  logic                   div_start;
  rem_sts_t               div_sts;
  logic [COUNT_W-1:0]     goal;

  // A target of zero behaves as a target of one.
  assign goal = (target_q == '0) ? COUNT_W'(1) : target_q;

  always_comb begin
    logic [NW-1:0]      n_plus;
    logic [COUNT_W-1:0] found_inc;

    state_d     = state_q;
    cand_d      = cand_q;
    fill_d      = fill_q;
    found_d     = found_q;
    run_over_d  = run_over_q;
    restart_d   = restart_q;
    abort_d     = abort_q;
    n_d         = n_q;
    idx_d       = idx_q;
    f_d         = f_q;
    sq_d        = sq_q;
    res_sts_d   = res_sts_q;
    res_last_d  = res_last_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_val_d   = out_val_q;
    out_ord_d   = out_ord_q;
    out_last_d  = out_last_q;
    out_sts_d   = out_sts_q;
    n_plus      = n_q + NW'(2);
    found_inc   = found_q + COUNT_W'(1);

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          restart_d = s_axis_tdata_i[0];
          abort_d   = s_axis_tdata_i[1];
          state_d   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (restart_q) begin
          // Restart wins over abort; the cleared run is decided next cycle.
          fill_d     = '0;
          cand_d     = VALUE_BITS'(1);
          found_d    = '0;
          run_over_d = 1'b0;
          restart_d  = 1'b0;
          abort_d    = 1'b0;
        end else if (abort_q) begin
          run_over_d = 1'b1;
          res_sts_d  = ST_ABORT;
          res_last_d = 1'b0;
          state_d    = S_EMIT;
        end else if (run_over_q || (found_q >= goal)) begin
          run_over_d = 1'b1;
          res_sts_d  = ST_DONE;
          res_last_d = 1'b0;
          state_d    = S_EMIT;
        end else if (cand_q <= VALUE_BITS'(2)) begin
          n_d     = NW'(2);
          cand_d  = VALUE_BITS'(3);
          state_d = S_COUNT;
        end else begin
          n_d     = {1'b0, cand_q | VALUE_BITS'(1)};
          idx_d   = '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (n_q > VMASK) begin
          // No prime left in the value range.
          run_over_d = 1'b1;
          res_sts_d  = ST_DONE;
          res_last_d = 1'b0;
          state_d    = S_EMIT;
        end else if (idx_q >= fill_q) begin
          state_d = S_FOUND;
        end else begin
          rd_en   = 1'b1;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        f_d     = rd_q;
        sq_d    = SQ_W'(rd_q) * SQ_W'(rd_q);
        state_d = S_CMP;
      end
      S_CMP: begin
        if ((f_q == '0) || (CMPW'(sq_q) > CMPW'(n_q))) begin
          state_d = S_FOUND;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          if (div_sts.zero) begin
            n_d   = n_plus;
            idx_d = '0;
          end else begin
            idx_d = idx_q + FW'(1);
          end
          state_d = S_RD;
        end
      end
      S_FOUND: begin
        if ((CMPW'(n_q) <= CMPW'(goal)) && (fill_q < FW'(TABLE_DEPTH))) begin
          wr_en  = 1'b1;
          fill_d = fill_q + FW'(1);
        end
        if (n_plus > VMASK) begin
          cand_d = VMASK[VALUE_BITS-1:0];
        end else begin
          cand_d = n_plus[VALUE_BITS-1:0];
        end
        state_d = S_COUNT;
      end
      S_COUNT: begin
        found_d    = found_inc;
        res_sts_d  = ST_PRIME;
        res_last_d = (found_inc >= goal);
        if (found_inc >= goal) begin
          run_over_d = 1'b1;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_val_d   = (res_sts_q == ST_PRIME) ? n_q[VALUE_BITS-1:0] : '0;
          out_ord_d   = found_q;
          out_last_d  = res_last_q;
          out_sts_d   = res_sts_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      target_q    <= COUNT_W'(1);
      cand_q      <= VALUE_BITS'(1);
      fill_q      <= '0;
      found_q     <= '0;
      run_over_q  <= 1'b0;
      restart_q   <= 1'b0;
      abort_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        target_q <= cfg_wdata_i;
      end
      cand_q      <= cand_d;
      fill_q      <= fill_d;
      found_q     <= found_d;
      run_over_q  <= run_over_d;
      restart_q   <= restart_d;
      abort_q     <= abort_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    idx_q      <= idx_d;
    f_q        <= f_d;
    sq_q       <= sq_d;
    res_sts_q  <= res_sts_d;
    res_last_q <= res_last_d;
    out_val_q  <= out_val_d;
    out_ord_q  <= out_ord_d;
    out_last_q <= out_last_d;
    out_sts_q  <= out_sts_d;
  end

  // Prime table. Writes happen only between candidates and always land at the
  // fill count, above every address that the trial loop reads, so a read never
  // meets a write to the same entry and no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[fill_q[IW-1:0]] <= ENTRY_W'(n_q);
    end
    if (rd_en) begin
      rd_q <= mem[idx_q[IW-1:0]];
    end
  end

  ptdg_rem_unit #(
    .DW (VALUE_BITS)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_q[VALUE_BITS-1:0]),
    .divisor_i  (f_q),
    .sts_o      (div_sts)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = ODW'({out_ord_q, out_val_q});
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_sts_q;

  `include "prime_trial_division_generator_assert.svh"

  `PTDG_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FW'(TABLE_DEPTH))
  `PTDG_ASSERT_NOW(a_div_nonzero, div_start, (f_q != '0) && !div_sts.busy)
  `PTDG_ASSERT_NOW(a_nonprime_clean, m_axis_tvalid_o && (m_axis_tuser_o != ST_PRIME),
                   (m_axis_tdata_o[VALUE_BITS-1:0] == '0) && !m_axis_tlast_o)
  `PTDG_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

endmodule

// ----- test/prime_trial_division_generator_tb.sv -----
// ---------------------------------------------------------------------------
// Prime trial division generator testbench
// Streams requests into the generator and checks every result word against
// a predictor that walks the same runs, under changing run lengths, random
// idling on both stream sides and one long back-pressure stretch.
// ---------------------------------------------------------------------------
module prime_trial_division_generator_tb;

  import ptdg_pkg::*;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned VALUE_BITS  = 18;
  localparam int unsigned VALUE_MAX   = (1 << VALUE_BITS) - 1;
  localparam int unsigned COUNT_MASK  = (1 << COUNT_W) - 1;
  localparam int unsigned RESULT_W    = ((VALUE_BITS + COUNT_W + 7) / 8) * 8;
  // Watchdog limit, sized for runs made only of the slowest requests near
  // the top of the range.
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 50;

  // How the two stream sides idle during a stretch of the run.
  typedef enum logic [2:0] {
    MODE_FREE,
    MODE_SEND_IDLE,
    MODE_RECV_STALL,
    MODE_BOTH,
    MODE_PRESSURE
  } idle_mode_e;

  // One result word as the generator should produce it.
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [COUNT_W-1:0]    ordinal;
    logic                  last;
    status_e               status;
  } prime_word_t;

  // The scoreboard keeps its own copy of the run state and the run length,
  // works out the word each accepted request must cause, and matches the
  // words that come back in order.
  class prime_scoreboard;
    logic [ENTRY_W-1:0] stored_primes [TABLE_DEPTH];
    int unsigned        fill;
    int unsigned        next_cand;
    int unsigned        found;
    bit                 finished;
    int unsigned        run_length;
    prime_word_t        expected_words [$];
    int unsigned        errors;

    function new();
      run_length = 1;
      errors     = 0;
      clear_run();
    endfunction

    function void clear_run();
      fill      = 0;
      next_cand = 1;
      found     = 0;
      finished  = 1'b0;
    endfunction

    function void set_run_length(logic [COUNT_W-1:0] v);
      run_length = v;
    endfunction

    function int unsigned pending_words();
      return expected_words.size();
    endfunction

    // A candidate is taken as prime when no stored prime up to its square
    // root divides it, or when the stored primes run out first.
    function bit survives_table(int unsigned n);
      int unsigned f;
      for (int unsigned i = 0; i < fill && i < TABLE_DEPTH; i++) begin
        f = stored_primes[i];
        if (f == 0 || f * f > n) break;
        if (n % f == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void push_word(int unsigned value, int unsigned ord, bit last, status_e sts);
      prime_word_t w;
      w.value   = value[VALUE_BITS-1:0];
      w.ordinal = ord[COUNT_W-1:0];
      w.last    = last;
      w.status  = sts;
      expected_words.push_back(w);
    endfunction

    function void note_request(bit restart, bit abort_bit);
      int unsigned goal;
      int unsigned n;
      bit          last;
      goal = (run_length == 0) ? 1 : run_length;
      // Restart wins over abort; the same request then yields 2.
      if (restart) begin
        clear_run();
      end else if (abort_bit) begin
        finished = 1'b1;
        push_word(0, found, 1'b0, ST_ABORT);
        return;
      end
      if (finished || found >= goal) begin
        finished = 1'b1;
        push_word(0, found, 1'b0, ST_DONE);
        return;
      end
      if (next_cand <= 2) begin
        n         = 2;
        next_cand = 3;
      end else begin
        n = next_cand | 1;
        while (n <= VALUE_MAX && !survives_table(n)) n += 2;
        if (n > VALUE_MAX) begin
          finished = 1'b1;
          push_word(0, found, 1'b0, ST_DONE);
          return;
        end
        // Only primes up to the run length are kept, and only while there
        // is room in the table.
        if (n <= goal && fill < TABLE_DEPTH) begin
          stored_primes[fill] = n[ENTRY_W-1:0];
          fill++;
        end
        next_cand = (n + 2) & VALUE_MAX;
        if (next_cand < n) next_cand = VALUE_MAX;
      end
      found = (found + 1) & COUNT_MASK;
      last  = (found >= goal);
      if (last) finished = 1'b1;
      push_word(n, found, last, ST_PRIME);
    endfunction

    function void check_result(logic [VALUE_BITS-1:0] value, logic [COUNT_W-1:0] ord,
                               logic last, logic [STS_W-1:0] sts);
      prime_word_t w;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: value %0d ordinal %0d", value, ord);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      if (w.value !== value) begin
        $error("prime_value: expected %0d, got %0d", w.value, value);
        errors++;
      end
      if (w.ordinal !== ord) begin
        $error("ordinal: expected %0d, got %0d", w.ordinal, ord);
        errors++;
      end
      if (w.last !== last) begin
        $error("last: expected %0b, got %0b", w.last, last);
        errors++;
      end
      if (w.status !== sts) begin
        $error("status: expected %0d, got %0d", w.status, sts);
        errors++;
      end
    endfunction
  endclass

  // All inputs of the block hold known values from time zero.
  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [COUNT_W-1:0]    cfg_wdata_i     = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [7:0]            s_axis_tdata_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [RESULT_W-1:0]   m_axis_tdata_o;
  logic                  m_axis_tlast_o;
  logic [STS_W-1:0]      m_axis_tuser_o;

  idle_mode_e            idle_mode   = MODE_FREE;
  int unsigned           cycle_count = 0;
  int unsigned           hold_left   = 0;
  bit                    hold_done   = 1'b0;
  int unsigned           requests_sent = 0;

  prime_scoreboard sb = new();

  prime_trial_division_generator #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("prime_trial_division_generator test failed");
    $finish;
  end

  // The sender skips a cycle according to the current idling mode.
  function automatic bit sender_idles();
    case (idle_mode)
      MODE_SEND_IDLE: return $urandom_range(99) < 88;
      MODE_BOTH:      return $urandom_range(99) < 27;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      MODE_RECV_STALL: return $urandom_range(99) < 88;
      MODE_BOTH:       return $urandom_range(99) < 27;
      default:         return 1'b0;
    endcase
  endfunction

  // Receiver side. Outputs are sampled at the rising edge, where they still
  // hold the values from before the edge, so a word counts as taken when
  // both tvalid and our registered tready were high. The long hold-off of
  // the pressure stretch is counted here, in cycles, while the sender goes
  // on offering requests.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result(m_axis_tdata_o[VALUE_BITS-1:0],
                      m_axis_tdata_o[VALUE_BITS +: COUNT_W],
                      m_axis_tlast_o, m_axis_tuser_o);
    end
    if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (idle_mode == MODE_PRESSURE && !hold_done) begin
      hold_left       <= HOLD_CYCLES;
      hold_done       <= 1'b1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= !receiver_stalls();
    end
  end

  // Offers one request word and returns at the edge that takes it. tvalid
  // is left high after the transfer, so a request that follows at once
  // keeps it high without lowering it in the same time step; wait_for_results
  // lowers it when the stream pauses.
  task automatic send_request(input bit restart, input bit abort_bit);
    if (sender_idles()) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
      while (sender_idles()) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'b0, abort_bit, restart};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_request(restart, abort_bit);
    requests_sent++;
  endtask

  // Stops offering requests and waits until every expected word has come.
  task automatic wait_for_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_words() != 0) @(posedge clk_i);
  endtask

  // The run length is written only while the generator is idle.
  task automatic write_run_length(input logic [COUNT_W-1:0] v);
    wait_for_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_run_length(v);
    @(posedge clk_i);
  endtask

  // Mostly short runs keep the primes small and the requests cheap; now and
  // then a longer run, a run of 12285, the all-ones word and zero.
  function automatic logic [COUNT_W-1:0] pick_run_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return COUNT_W'($urandom_range(40, 1));
    if (r < 88) return COUNT_W'($urandom_range(300, 41));
    if (r < 94) return 14'd12285;
    if (r < 97) return {COUNT_W{1'b1}};
    return '0;
  endfunction

  // A well-formed run: a restart followed by plain requests, with a little
  // noise from aborts and early restarts mixed in.
  task automatic run_sequence(input int unsigned len);
    int unsigned r;
    send_request(1'b1, 1'($urandom_range(1)));
    repeat (len) begin
      r = $urandom_range(99);
      if (r < 6) send_request(1'b0, 1'b1);
      else if (r < 9) send_request(1'b1, 1'($urandom_range(1)));
      else send_request(1'b0, 1'b0);
    end
  endtask

  initial begin : stimulus
    logic [COUNT_W-1:0] len_reg;
    int unsigned        goal;
    int unsigned        seg_start;
    int unsigned        cap;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. With the reset run length of one, the first request
    // gives 2 marked last and the run is then finished.
    send_request(1'b0, 1'b0);
    send_request(1'b0, 1'b0);
    send_request(1'b0, 1'b1);
    // Restart together with abort: the restart wins.
    send_request(1'b1, 1'b1);

    // A run length of zero acts as one.
    write_run_length('0);
    send_request(1'b1, 1'b0);
    send_request(1'b0, 1'b0);

    // A run length of 12285: the first primes, then an abort, after which
    // the run stays over.
    write_run_length(14'd12285);
    send_request(1'b1, 1'b0);
    repeat (5) send_request(1'b0, 1'b0);
    send_request(1'b0, 1'b1);
    send_request(1'b0, 1'b0);

    // Shortening the run length below the count already reached ends the
    // run on the next request.
    write_run_length(14'd10);
    send_request(1'b1, 1'b0);
    repeat (3) send_request(1'b0, 1'b0);
    write_run_length(14'd3);
    send_request(1'b0, 1'b0);

    // Random part in segments, each with its own idling mode and run length.
    // One segment carries the long receiver hold-off.
    for (int unsigned seg = 0; seg < 10; seg++) begin
      len_reg = pick_run_length();
      write_run_length(len_reg);
      idle_mode <= (seg == 5) ? MODE_PRESSURE : idle_mode_e'(seg % 4);
      goal      = (len_reg == 0) ? 1 : len_reg;
      seg_start = requests_sent;
      // Sometimes the old run goes on under the new run length first.
      if ($urandom_range(1)) repeat ($urandom_range(3, 1)) send_request(1'b0, 1'b0);
      while (requests_sent - seg_start < 24) begin
        cap = (goal + 2 > 60) ? 60 : goal + 2;
        run_sequence($urandom_range(cap, 1));
      end
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_words() == 0) begin
      $display("prime_trial_division_generator test passed");
    end else begin
      $display("prime_trial_division_generator test failed");
    end
    $finish;
  end

endmodule

// ----- prime_trial_division_generator.f -----
+incdir+rtl
rtl/ptdg_pkg.sv
rtl/ptdg_rem_unit.sv
rtl/prime_trial_division_generator.sv
test/prime_trial_division_generator_tb.sv
